### design/bat_pkg.sv
// ---------------------------------------------------------------------------
// bat_pkg: shared types and codes for the breakpoint address table
// Transaction structs, operation and status codes, and controller/datapath
// command and status groups.
// ---------------------------------------------------------------------------
package bat_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int ADDR_W        = 16;

	localparam logic [1:0] OP_CHECK  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_PRESENT   = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic [4:0] count;
		logic       hit;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic can_commit;
	} sts_t;

endpackage

### design/bat_ctrl.sv
// ---------------------------------------------------------------------------
// bat_ctrl: controller for the breakpoint address table
// Accepts a request, sweeps the slots, then commits the result.
// ---------------------------------------------------------------------------
module bat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bat_pkg::sts_t sts,
	output bat_pkg::cmd_t cmd
);
	import bat_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.can_commit) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/bat_dp.sv
// ---------------------------------------------------------------------------
// bat_dp: datapath for the breakpoint address table
// Slot memory, valid bits, count, sweep registers and result register.
// ---------------------------------------------------------------------------
module bat_dp #(
	parameter int SLOTS = bat_pkg::SLOTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bat_pkg::req_t req,
	input  bat_pkg::cmd_t cmd,
	output bat_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bat_pkg::rsp_t rsp
);
	import bat_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);

	logic [ADDR_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [CW-1:0]     count_q;

	logic [1:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IW-1:0]     idx_q;

	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [ADDR_W-1:0] rd_s1;
	logic              vbit_s1;

	logic              match_found_q;
	logic [IW-1:0]     match_idx_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;
	rsp_t              res;
	logic              do_write;
	logic              do_clear;

	logic [IW+3:0]     match_ext;
	logic [IW+3:0]     free_ext;
	logic [CW+4:0]     cnt_inc_ext;
	logic [CW+4:0]     cnt_dec_ext;
	logic [CW+4:0]     cnt_ext;

	assign sts.last       = (idx_q == LAST_IDX);
	assign sts.can_commit = !rsp_valid_q || !rsp_stall;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

	assign match_ext   = {4'b0, match_idx_q};
	assign free_ext    = {4'b0, free_idx_q};
	assign cnt_inc_ext = {5'b0, count_q + CW'(1)};
	assign cnt_dec_ext = {5'b0, count_q - CW'(1)};
	assign cnt_ext     = {5'b0, count_q};

	always_comb begin
		res      = '0;
		res.count = cnt_ext[4:0];
		do_write = 1'b0;
		do_clear = 1'b0;
		case (op_q)
			OP_CHECK: begin
				res.hit = match_found_q;
			end
			OP_ADD: begin
				if (count_q >= FULL_CNT) begin
					res.status = ST_FULL;
				end else if (match_found_q) begin
					res.status = ST_PRESENT;
					res.slot   = match_ext[3:0];
				end else if (free_found_q) begin
					do_write  = 1'b1;
					res.slot  = free_ext[3:0];
					res.count = cnt_inc_ext[4:0];
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (match_found_q) begin
					do_clear  = 1'b1;
					res.slot  = match_ext[3:0];
					res.count = cnt_dec_ext[4:0];
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1 <= mem[idx_q];
		end
		if (cmd.commit && do_write) begin
			mem[free_idx_q] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= req.operation;
			addr_q <= req.address;
		end
		idx_s1  <= idx_q;
		vbit_s1 <= valid_q[idx_q];
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			count_q       <= '0;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				idx_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (cmd.issue && !sts.last) begin
					idx_q <= idx_q + IW'(1);
				end
				if (vld_s1 && vbit_s1 && (rd_s1 == addr_q) && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
				end
				if (vld_s1 && !vbit_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end
			if (cmd.commit && do_write) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q             <= count_q + CW'(1);
			end
			if (cmd.commit && do_clear) begin
				valid_q[match_idx_q] <= 1'b0;
				count_q              <= count_q - CW'(1);
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/breakpoint_address_table.sv
// ---------------------------------------------------------------------------
// breakpoint_address_table: table of breakpoint address slots
// Each request is a check, add or remove of a 16-bit address; each gives
// exactly one response with status, slot, valid count and hit.
//
// Request channel req/req_valid/req_stall, response channel
// rsp/rsp_valid/rsp_stall; a transaction moves when valid is high and stall
// is low. After a request is taken the slot memory is swept one slot per
// cycle, and a new request is taken only once the last one is committed;
// the single read port of the slot memory sets this sweep rate. The
// response sits in an output register, so the next request is taken and
// swept while it waits; the result of that request is held back until the
// receiver lifts rsp_stall. Reset clears all valid bits, the count and both
// handshakes; slot addresses need no clear.
// ---------------------------------------------------------------------------
module breakpoint_address_table #(
	parameter int SLOTS = bat_pkg::SLOTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bat_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bat_pkg::rsp_t rsp
);
	import bat_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bat_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
